### rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Types, constants and field helpers for the polling request sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int ENTRIES   = 8;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int CODE_W    = 8;
    localparam int FAIL_W    = 4;
    localparam int IVL_W     = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        CMD_RESPONSE = 3'd0,
        CMD_TIMEOUT  = 3'd1,
        CMD_ADVANCE  = 3'd2,
        CMD_SEND     = 3'd3,
        CMD_DISABLE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_ENTRY_COUNT = 3'd0,
        CFG_ENTRY_CODES = 3'd1,
        CFG_IVL_LOW     = 3'd2,
        CFG_IVL_HIGH    = 3'd3,
        CFG_FAIL_LIMITS = 3'd4,
        CFG_TMO_MASK    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_ISSUE,
        S_DONE
    } t_state;

    function automatic logic [CODE_W-1:0] code_of(
        input logic [ENTRIES*CODE_W-1:0] codes,
        input logic [IDX_W-1:0]          idx
    );
        return codes[{idx, 3'b000} +: CODE_W];
    endfunction

    function automatic logic [IVL_W-1:0] interval_of(
        input logic [CFG_W-1:0] ivl_low,
        input logic [CFG_W-1:0] ivl_high,
        input logic [IDX_W-1:0] idx
    );
        logic [2*CFG_W-1:0] all_ivl;
        all_ivl = {ivl_high, ivl_low};
        return all_ivl[{idx, 4'b0000} +: IVL_W];
    endfunction

    function automatic logic [FAIL_W-1:0] limit_of(
        input logic [ENTRIES*FAIL_W-1:0] limits,
        input logic [IDX_W-1:0]          idx
    );
        return limits[{idx, 2'b00} +: FAIL_W];
    endfunction

endpackage

### rtl/polling_request_sequencer_top.sv
// ----------------------------------------------------------------------------
// polling_request_sequencer_top
// Walks a table of polled request codes, tracks replies and soft timeouts.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    cmd, code, now_ms, send_allowed
//  result    out        o_out_valid / i_out_ready  handled, sent, sent_code,
//                                                  arm_timeout, cycle_done
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
//  one transaction steps through lookup, a forward scan of one entry per cycle
//  through the shared elapsed-time compare, issue and hand-off to the result
//  register
//  one transaction at a time; o_in_ready is high only while idle
//  a finished result waits in the output register; the next transaction is
//  taken meanwhile and its result waits in hand-off until the register frees
//  synchronous active-low reset clears configuration and all entry state
// ----------------------------------------------------------------------------
module polling_request_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_code,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_send_allowed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_handled,
    output logic        o_sent,
    output logic [7:0]  o_sent_code,
    output logic        o_arm_timeout,
    output logic        o_cycle_done,
    input  logic        i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [prs_pkg::CFG_W-1:0]     i_cfg_wdata
);

    // configuration
    logic [prs_pkg::CNT_W-1:0]                    r_entry_count;
    logic [prs_pkg::ENTRIES*prs_pkg::CODE_W-1:0]  r_entry_codes;
    logic [prs_pkg::CFG_W-1:0]                    r_ivl_low;
    logic [prs_pkg::CFG_W-1:0]                    r_ivl_high;
    logic [prs_pkg::ENTRIES*prs_pkg::FAIL_W-1:0]  r_fail_limits;
    logic [prs_pkg::ENTRIES-1:0]                  r_tmo_mask;

    // entry state
    logic [prs_pkg::ENTRIES-1:0]                  r_disabled, n_disabled;
    logic [prs_pkg::ENTRIES-1:0]                  r_awaiting, n_awaiting;
    logic [prs_pkg::ENTRIES-1:0][prs_pkg::FAIL_W-1:0] r_failures, n_failures;
    logic [prs_pkg::TIME_BITS-1:0]                r_sent_time [prs_pkg::ENTRIES];
    logic                                         w_stamp_we;
    logic [prs_pkg::IDX_W-1:0]                    w_stamp_idx;

    // sequencer
    prs_pkg::t_state                              r_state, n_state;
    logic [2:0]                                   r_cmd, n_cmd;
    logic [prs_pkg::CODE_W-1:0]                   r_code, n_code;
    logic [prs_pkg::TIME_BITS-1:0]                r_now, n_now;
    logic [prs_pkg::ENTRIES-1:0]                  r_allowed, n_allowed;
    logic [prs_pkg::CNT_W-1:0]                    r_idx, n_idx;

    // pending result
    logic r_res_handled, n_res_handled;
    logic r_res_sent, n_res_sent;
    logic [prs_pkg::CODE_W-1:0] r_res_code, n_res_code;
    logic r_res_arm, n_res_arm;
    logic r_res_done, n_res_done;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_handled, n_handled;
    logic r_sent, n_sent;
    logic [prs_pkg::CODE_W-1:0] r_sent_code, n_sent_code;
    logic r_arm, n_arm;
    logic r_cycle_done, n_cycle_done;

    // match unit and scan compare
    logic [prs_pkg::CNT_W-1:0]   w_used;
    logic [prs_pkg::ENTRIES-1:0] w_match;
    logic [prs_pkg::ENTRIES-1:0] w_tmatch;
    logic [prs_pkg::IDX_W-1:0]   w_first;
    logic [prs_pkg::IDX_W-1:0]   w_tfirst;
    logic                        w_any;
    logic                        w_tany;
    logic [prs_pkg::CNT_W-1:0]   w_after;
    logic [prs_pkg::IDX_W-1:0]   w_sidx;
    logic [prs_pkg::TIME_BITS-1:0] w_elapsed;
    logic [prs_pkg::IVL_W-1:0]   w_ivl;
    logic                        w_eligible;
    logic [prs_pkg::FAIL_W-1:0]  w_fail_inc;

    assign w_used = (r_entry_count > prs_pkg::CNT_W'(prs_pkg::ENTRIES))
                  ? prs_pkg::CNT_W'(prs_pkg::ENTRIES) : r_entry_count;

    always_comb begin
        w_match  = '0;
        w_first  = '0;
        w_tfirst = '0;
        for (int i = 0; i < prs_pkg::ENTRIES; i++) begin
            w_match[i] = (prs_pkg::CNT_W'(i) < w_used)
                && (prs_pkg::code_of(r_entry_codes, prs_pkg::IDX_W'(i)) == r_code);
        end
        w_tmatch = w_match & r_awaiting;
        for (int i = prs_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = prs_pkg::IDX_W'(i);
            end
            if (w_tmatch[i]) begin
                w_tfirst = prs_pkg::IDX_W'(i);
            end
        end
        w_any  = |w_match;
        w_tany = |w_tmatch;
    end

    assign w_after    = w_any ? ({1'b0, w_first} + prs_pkg::CNT_W'(1)) : '0;
    assign w_sidx     = r_idx[prs_pkg::IDX_W-1:0];
    assign w_elapsed  = r_now - r_sent_time[w_sidx];
    assign w_ivl      = prs_pkg::interval_of(r_ivl_low, r_ivl_high, w_sidx);
    assign w_eligible = !r_disabled[w_sidx] && r_allowed[w_sidx]
                     && !((w_ivl != '0)
                          && (w_elapsed < prs_pkg::TIME_BITS'(w_ivl)));
    assign w_fail_inc = (r_failures[w_tfirst] == '1) ? r_failures[w_tfirst]
                      : r_failures[w_tfirst] + prs_pkg::FAIL_W'(1);

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_code        = r_code;
        n_now         = r_now;
        n_allowed     = r_allowed;
        n_idx         = r_idx;
        n_disabled    = r_disabled;
        n_awaiting    = r_awaiting;
        n_failures    = r_failures;
        n_res_handled = r_res_handled;
        n_res_sent    = r_res_sent;
        n_res_code    = r_res_code;
        n_res_arm     = r_res_arm;
        n_res_done    = r_res_done;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_handled     = r_handled;
        n_sent        = r_sent;
        n_sent_code   = r_sent_code;
        n_arm         = r_arm;
        n_cycle_done  = r_cycle_done;
        w_stamp_we    = 1'b0;
        w_stamp_idx   = w_first;
        o_in_ready    = 1'b0;

        unique case (r_state)
            prs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd         = i_cmd;
                    n_code        = i_code;
                    n_now         = i_now_ms[prs_pkg::TIME_BITS-1:0];
                    n_allowed     = i_send_allowed;
                    n_res_handled = 1'b0;
                    n_res_sent    = 1'b0;
                    n_res_code    = '0;
                    n_res_arm     = 1'b0;
                    n_res_done    = 1'b0;
                    n_state       = prs_pkg::S_LOOK;
                end
            end
            prs_pkg::S_LOOK: begin
                n_idx   = w_after;
                n_state = prs_pkg::S_DONE;
                case (r_cmd)
                    prs_pkg::CMD_RESPONSE: begin
                        if (w_any) begin
                            n_awaiting[w_first] = 1'b0;
                            n_failures[w_first] = '0;
                            n_res_handled       = 1'b1;
                            n_state             = prs_pkg::S_SCAN;
                        end
                    end
                    prs_pkg::CMD_TIMEOUT: begin
                        if (w_tany) begin
                            n_awaiting[w_tfirst] = 1'b0;
                            n_failures[w_tfirst] = w_fail_inc;
                            if (w_fail_inc >= prs_pkg::limit_of(r_fail_limits, w_tfirst)) begin
                                n_disabled[w_tfirst] = 1'b1;
                            end
                            n_state = prs_pkg::S_SCAN;
                        end
                    end
                    prs_pkg::CMD_ADVANCE: begin
                        n_state = prs_pkg::S_SCAN;
                    end
                    prs_pkg::CMD_SEND: begin
                        n_state = prs_pkg::S_ISSUE;
                    end
                    prs_pkg::CMD_DISABLE: begin
                        if (w_any) begin
                            n_disabled[w_first] = 1'b1;
                        end
                    end
                    default: begin
                        n_state = prs_pkg::S_DONE;
                    end
                endcase
            end
            prs_pkg::S_SCAN: begin
                if (r_idx >= w_used) begin
                    n_res_done = 1'b1;
                    n_state    = prs_pkg::S_DONE;
                end else if (w_eligible) begin
                    n_code  = prs_pkg::code_of(r_entry_codes, w_sidx);
                    n_state = prs_pkg::S_ISSUE;
                end else begin
                    n_idx = r_idx + prs_pkg::CNT_W'(1);
                end
            end
            prs_pkg::S_ISSUE: begin
                if (w_any && !r_disabled[w_first] && r_allowed[w_first]) begin
                    n_awaiting[w_first] = 1'b1;
                    w_stamp_we          = 1'b1;
                    n_res_sent          = 1'b1;
                    n_res_code          = prs_pkg::code_of(r_entry_codes, w_first);
                    n_res_arm           = r_tmo_mask[w_first];
                end
                n_state = prs_pkg::S_DONE;
            end
            prs_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_handled    = r_res_handled;
                    n_sent       = r_res_sent;
                    n_sent_code  = r_res_code;
                    n_arm        = r_res_arm;
                    n_cycle_done = r_res_done;
                    n_state      = prs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_disabled  <= '0;
            r_awaiting  <= '0;
            r_failures  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_disabled  <= n_disabled;
            r_awaiting  <= n_awaiting;
            r_failures  <= n_failures;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < prs_pkg::ENTRIES; i++) begin
                r_sent_time[i] <= '0;
            end
        end else if (w_stamp_we) begin
            r_sent_time[w_stamp_idx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_code        <= n_code;
        r_now         <= n_now;
        r_allowed     <= n_allowed;
        r_idx         <= n_idx;
        r_res_handled <= n_res_handled;
        r_res_sent    <= n_res_sent;
        r_res_code    <= n_res_code;
        r_res_arm     <= n_res_arm;
        r_res_done    <= n_res_done;
        r_handled     <= n_handled;
        r_sent        <= n_sent;
        r_sent_code   <= n_sent_code;
        r_arm         <= n_arm;
        r_cycle_done  <= n_cycle_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_entry_codes <= '0;
            r_ivl_low     <= '0;
            r_ivl_high    <= '0;
            r_fail_limits <= '0;
            r_tmo_mask    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prs_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[prs_pkg::CNT_W-1:0];
                prs_pkg::CFG_ENTRY_CODES: r_entry_codes <= i_cfg_wdata;
                prs_pkg::CFG_IVL_LOW:     r_ivl_low     <= i_cfg_wdata;
                prs_pkg::CFG_IVL_HIGH:    r_ivl_high    <= i_cfg_wdata;
                prs_pkg::CFG_FAIL_LIMITS:
                    r_fail_limits <= i_cfg_wdata[prs_pkg::ENTRIES*prs_pkg::FAIL_W-1:0];
                prs_pkg::CFG_TMO_MASK:    r_tmo_mask    <= i_cfg_wdata[prs_pkg::ENTRIES-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_handled     = r_handled;
    assign o_sent        = r_sent;
    assign o_sent_code   = r_sent_code;
    assign o_arm_timeout = r_arm;
    assign o_cycle_done  = r_cycle_done;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a transaction is in progress");

    a_quiet_when_unsent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sent) |-> (o_sent_code == '0 && !o_arm_timeout))
        else $error("code or timer flag without an issued request");

    a_sent_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_sent && o_cycle_done))
        else $error("request issued and cycle ended together");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prs_pkg::S_SCAN) |-> (r_idx <= prs_pkg::CNT_W'(prs_pkg::ENTRIES)))
        else $error("scan index past the table");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polling request sequencer. A behavioural
// model of the request table predicts one result per input transaction; the
// results are checked field by field in order. Stimulus covers a directed
// pass, well-formed poll cycles on random tables under four idling mixes, a
// long output hold-off and extreme register settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    localparam logic [prs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [prs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic       handled;
        logic       sent;
        logic [7:0] sent_code;
        logic       arm_timeout;
        logic       cycle_done;
    } t_poll_result;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [2:0]                    i_cmd          = '0;
    logic [7:0]                    i_code         = '0;
    logic [31:0]                   i_now_ms       = '0;
    logic [7:0]                    i_send_allowed = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic                          o_handled;
    logic                          o_sent;
    logic [7:0]                    o_sent_code;
    logic                          o_arm_timeout;
    logic                          o_cycle_done;
    logic                          i_cfg_we       = 1'b0;
    logic [prs_pkg::CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [prs_pkg::CFG_W-1:0]     i_cfg_wdata    = '0;

    // model copy of the registers
    bit [3:0]  cfg_count;
    bit [63:0] cfg_codes;
    bit [63:0] cfg_ivl_lo;
    bit [63:0] cfg_ivl_hi;
    bit [31:0] cfg_limits;
    bit [7:0]  cfg_tmo;

    // model copy of the per-entry state
    bit        ent_disabled [prs_pkg::ENTRIES];
    bit        ent_awaiting [prs_pkg::ENTRIES];
    bit [3:0]  ent_fails    [prs_pkg::ENTRIES];
    bit [31:0] ent_stamp    [prs_pkg::ENTRIES];

    t_poll_result expected_q[$];
    t_poll_result last_result = '0;
    logic [31:0]  poll_now    = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;

    int items_sent   = 0;
    int checked      = 0;
    int issued       = 0;
    int cycle_ends   = 0;
    int handled_resp = 0;
    int mismatches   = 0;

    polling_request_sequencer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_code         (i_code),
        .i_now_ms       (i_now_ms),
        .i_send_allowed (i_send_allowed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_handled      (o_handled),
        .o_sent         (o_sent),
        .o_sent_code    (o_sent_code),
        .o_arm_timeout  (o_arm_timeout),
        .o_cycle_done   (o_cycle_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int entries_in_use();
        return (cfg_count > prs_pkg::ENTRIES) ? prs_pkg::ENTRIES : int'(cfg_count);
    endfunction

    function automatic logic [7:0] table_code(int i);
        return cfg_codes[8*i +: 8];
    endfunction

    function automatic logic [15:0] table_interval(int i);
        return (i < 4) ? cfg_ivl_lo[16*i +: 16] : cfg_ivl_hi[16*(i-4) +: 16];
    endfunction

    function automatic int first_with_code(logic [7:0] code);
        for (int i = 0; i < entries_in_use(); i++) begin
            if (table_code(i) == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void issue_request(logic [7:0] code, logic [31:0] now,
                                          logic [7:0] allowed, inout t_poll_result res);
        int f;
        f = first_with_code(code);
        if (f < 0 || ent_disabled[f] || !allowed[f]) begin
            return;
        end
        ent_awaiting[f] = 1'b1;
        ent_stamp[f]    = now;
        res.sent        = 1'b1;
        res.sent_code   = table_code(f);
        res.arm_timeout = cfg_tmo[f];
    endfunction

    function automatic void scan_and_issue(logic [7:0] code, logic [31:0] now,
                                           logic [7:0] allowed, inout t_poll_result res);
        int          s;
        int          i;
        logic [31:0] elapsed;
        logic [15:0] ivl;
        s = first_with_code(code);
        for (i = (s < 0) ? 0 : s + 1; i < entries_in_use(); i++) begin
            elapsed = now - ent_stamp[i];
            ivl     = table_interval(i);
            if (!ent_disabled[i] && allowed[i] && !(ivl != 0 && elapsed < 32'(ivl))) begin
                issue_request(table_code(i), now, allowed, res);
                return;
            end
        end
        res.cycle_done = 1'b1;
    endfunction

    function automatic t_poll_result predict_event(logic [2:0] cmd, logic [7:0] code,
                                                   logic [31:0] now, logic [7:0] allowed);
        t_poll_result res;
        int           f;
        res = '0;
        case (cmd)
            prs_pkg::CMD_RESPONSE: begin
                f = first_with_code(code);
                if (f >= 0) begin
                    ent_awaiting[f] = 1'b0;
                    ent_fails[f]    = '0;
                    res.handled     = 1'b1;
                    scan_and_issue(code, now, allowed, res);
                end
            end
            prs_pkg::CMD_TIMEOUT: begin
                for (int i = 0; i < entries_in_use(); i++) begin
                    if (table_code(i) == code && ent_awaiting[i]) begin
                        ent_awaiting[i] = 1'b0;
                        if (ent_fails[i] < 4'd15) begin
                            ent_fails[i]++;
                        end
                        if (ent_fails[i] >= cfg_limits[4*i +: 4]) begin
                            ent_disabled[i] = 1'b1;
                        end
                        scan_and_issue(code, now, allowed, res);
                        break;
                    end
                end
            end
            prs_pkg::CMD_ADVANCE: scan_and_issue(code, now, allowed, res);
            prs_pkg::CMD_SEND: issue_request(code, now, allowed, res);
            prs_pkg::CMD_DISABLE: begin
                f = first_with_code(code);
                if (f >= 0) begin
                    ent_disabled[f] = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] pick_table_code();
        int n;
        n = entries_in_use();
        if (n == 0) begin
            return 8'($urandom);
        end
        return table_code($urandom_range(0, n - 1));
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        t_poll_result want;
        if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual handled %0b sent %0b code %0h",
                     $time, o_handled, o_sent, o_sent_code);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("handled", want.handled, o_handled);
        compare_field("sent", want.sent, o_sent);
        compare_field("sent_code", want.sent_code, o_sent_code);
        compare_field("arm_timeout", want.arm_timeout, o_arm_timeout);
        compare_field("cycle_done", want.cycle_done, o_cycle_done);
    endtask

    task automatic write_reg(logic [prs_pkg::CFG_IDX_W-1:0] idx,
                             logic [prs_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            prs_pkg::CFG_ENTRY_COUNT: cfg_count  = data[3:0];
            prs_pkg::CFG_ENTRY_CODES: cfg_codes  = data;
            prs_pkg::CFG_IVL_LOW:     cfg_ivl_lo = data;
            prs_pkg::CFG_IVL_HIGH:    cfg_ivl_hi = data;
            prs_pkg::CFG_FAIL_LIMITS: cfg_limits = data[31:0];
            prs_pkg::CFG_TMO_MASK:    cfg_tmo    = data[7:0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry random data
    task automatic load_table(logic [3:0] count, logic [63:0] codes, logic [63:0] ivl_lo,
                              logic [63:0] ivl_hi, logic [31:0] limits, logic [7:0] tmo);
        logic [prs_pkg::CFG_W-1:0] noise;
        noise      = {$urandom, $urandom};
        noise[3:0] = count;
        write_reg(prs_pkg::CFG_ENTRY_COUNT, noise);
        write_reg(prs_pkg::CFG_ENTRY_CODES, codes);
        write_reg(prs_pkg::CFG_IVL_LOW, ivl_lo);
        write_reg(prs_pkg::CFG_IVL_HIGH, ivl_hi);
        noise       = {$urandom, $urandom};
        noise[31:0] = limits;
        write_reg(prs_pkg::CFG_FAIL_LIMITS, noise);
        noise      = {$urandom, $urandom};
        noise[7:0] = tmo;
        write_reg(prs_pkg::CFG_TMO_MASK, noise);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_table();
        logic [3:0]   count;
        logic [63:0]  codes;
        logic [127:0] ivls;
        logic [31:0]  limits;
        int           r;
        int           j;
        int           k;
        r     = $urandom_range(0, 9);
        count = (r < 6) ? 4'd8 : (r < 9) ? 4'($urandom_range(1, 7)) : 4'($urandom_range(9, 15));
        codes = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, 7);
            k = $urandom_range(0, 7);
            codes[8*k +: 8] = codes[8*j +: 8];
        end
        for (int i = 0; i < prs_pkg::ENTRIES; i++) begin
            r = $urandom_range(0, 99);
            ivls[16*i +: 16] = (r < 40) ? 16'd0 :
                               (r < 85) ? 16'($urandom_range(1, 60)) :
                               (r < 95) ? 16'($urandom_range(61, 2000)) : 16'($urandom);
            limits[4*i +: 4] = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(2, 15));
        end
        load_table(count, codes, ivls[63:0], ivls[127:64], limits, 8'($urandom));
    endtask

    task automatic send_event(logic [2:0] cmd, logic [7:0] code, logic [31:0] now,
                              logic [7:0] allowed);
        t_poll_result res;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_code         <= code;
        i_now_ms       <= now;
        i_send_allowed <= allowed;
        do @(posedge i_clk); while (!o_in_ready);
        res = predict_event(cmd, code, now, allowed);
        expected_q = {expected_q, res};
        last_result = res;
        items_sent++;
        issued       += res.sent;
        cycle_ends   += res.cycle_done;
        handled_resp += res.handled;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed poll cycles: advance, then reply or time out on what was sent
    task automatic run_poll(int count);
        int         r;
        logic [2:0] cmd;
        logic [7:0] code;
        logic [7:0] allowed;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                poll_now += $urandom_range(0, 40);
            end else if (r < 96) begin
                poll_now += $urandom_range(41, 600);
            end else begin
                poll_now = $urandom;
            end
            allowed = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
            r = $urandom_range(0, 99);
            if (last_result.sent && r < 85) begin
                cmd  = ($urandom_range(0, 99) < 78) ? prs_pkg::CMD_RESPONSE
                                                    : prs_pkg::CMD_TIMEOUT;
                code = last_result.sent_code;
            end else if (!last_result.sent && r < 85) begin
                cmd  = prs_pkg::CMD_ADVANCE;
                code = ($urandom_range(0, 1) != 0) ? 8'($urandom) : pick_table_code();
            end else begin
                cmd = 3'($urandom_range(0, 7));
                if (cmd == prs_pkg::CMD_DISABLE && $urandom_range(0, 7) != 0) begin
                    cmd = prs_pkg::CMD_SEND;
                end
                code = ($urandom_range(0, 9) < 6) ? pick_table_code() : 8'($urandom);
            end
            send_event(cmd, code, poll_now, allowed);
        end
    endtask

    task automatic test_directed();
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        // five entries in use, entry 3 repeats the code of entry 1
        load_table(4'd5, 64'h3322_11A5_FF5A_FF00, 64'h0000_0064_0000_0000,
                   64'h0000_0000_0000_FFFF, 32'hFFF0_FF2F, 8'b0001_0101);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_event(prs_pkg::CMD_ADVANCE,  8'h77, 32'd0,  8'hFF);
        send_event(prs_pkg::CMD_RESPONSE, 8'h00, 32'd5,  8'hFF);
        send_event(prs_pkg::CMD_TIMEOUT,  8'hFF, 32'd9,  8'hFF);
        send_event(prs_pkg::CMD_TIMEOUT,  8'h77, 32'd10, 8'hFF);
        send_event(prs_pkg::CMD_RESPONSE, 8'h11, 32'd12, 8'hFF);
        send_event(prs_pkg::CMD_SEND,     8'h5A, 32'd20, 8'hFF);
        send_event(prs_pkg::CMD_SEND,     8'hA5, 32'd25, 8'h00);
        send_event(prs_pkg::CMD_SEND,     8'hEE, 32'd26, 8'hFF);
        send_event(prs_pkg::CMD_SEND,     8'hA5, 32'd30, 8'hFF);
        // failure limit of zero disables on the first timeout
        send_event(prs_pkg::CMD_TIMEOUT,  8'hA5, 32'd40, 8'hFF);
        send_event(prs_pkg::CMD_SEND,     8'hA5, 32'd41, 8'hFF);
        send_event(prs_pkg::CMD_DISABLE,  8'hA5, 32'd42, 8'hFF);
        send_event(prs_pkg::CMD_DISABLE,  8'hEE, 32'd43, 8'hFF);
        send_event(prs_pkg::CMD_ADVANCE,  8'h5A, 32'd50, 8'h00);
        // time wraps between stamp and check
        send_event(prs_pkg::CMD_ADVANCE,  8'h00, 32'hFFFF_FFF0, 8'hFF);
        send_event(prs_pkg::CMD_RESPONSE, 8'h5A, 32'h0000_0020, 8'hFF);
        send_event(prs_pkg::CMD_ADVANCE,  8'h77, 32'h0000_0030, 8'hFE);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
            send_event(3'(c), 8'($urandom), $urandom, 8'($urandom));
        end
        send_event(prs_pkg::CMD_RESPONSE, 8'hFF, 32'h0000_0040, 8'hFF);
        send_event(prs_pkg::CMD_SEND,     8'hFF, 32'h0000_0050, 8'hFD);
        send_event(prs_pkg::CMD_DISABLE,  8'h33, 32'h0000_0060, 8'hFF);
    endtask

    task automatic test_polling();
        int send_pcts [4] = '{0, 59, 0, 12};
        int recv_pcts [4] = '{0, 0, 59, 12};
        poll_now = $urandom;
        for (int m = 0; m < 4; m++) begin
            for (int t = 0; t < 2; t++) begin
                drain_results();
                load_random_table();
                send_idle_pct  = send_pcts[m];
                recv_stall_pct = recv_pcts[m];
                run_poll(150);
            end
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        load_table(4'd8, {$urandom, $urandom}, 64'h0, 64'h0, 32'hFFFF_FFFF, 8'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        run_poll(16);
        drain_results();
        run_poll(12);
    endtask

    task automatic test_extreme_tables();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        drain_results();
        load_table(4'd0, 64'h0, 64'h0, 64'h0, 32'h0, 8'h00);
        run_poll(15);
        drain_results();
        load_table(4'hF, {8{8'hFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, 32'hFFFF_FFFF, 8'hFF);
        run_poll(25);
        // every entry shares one code and disables on its first timeout
        drain_results();
        load_table(4'd8, 64'h0, 64'h0, 64'h0, 32'h0, 8'h00);
        run_poll(25);
    endtask

    // output side: accept, check and stall
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result();
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_q.size());
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_polling();
        test_backpressure();
        test_extreme_tables();
        drain_results();
        $display("covered %0d transactions: directed cases, poll cycles on random tables",
                 items_sent);
        $display("under four idling mixes, a long output hold-off and extreme tables;");
        $display("%0d checked, %0d issued, %0d cycle ends, %0d handled",
                 checked, issued, cycle_ends, handled_resp);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/prs_pkg.sv
rtl/polling_request_sequencer_top.sv
tb/tb_top.sv
